// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the lz77 window decompressor RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Boolean condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== rtl/lz77wd_pkg.sv =====
// Shared types and constants for the lz77 window decompressor.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package lz77wd_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int unsigned DEF_WINDOW_SIZE     = 4096;
  localparam int unsigned DEF_MAX_CHUNK_BYTES = 65536;

  // Fixed field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CLEN_W     = 17;
  localparam int unsigned FLAG_IDX_W = 3;
  localparam int unsigned TOK_LEN_W  = 4;
  localparam int unsigned CNT_W      = 5;   // copy length up to 15 + bias
  localparam int unsigned TOK_LEN_BIAS = 2;

  // Compressed-side beat
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              chunk_start;
    logic [CLEN_W-1:0] chunk_length;
  } in_beat_t;

  // Decompressed-side beat
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              chunk_last;
  } out_beat_t;

  // Controller states: four parse states take input, three do output work
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAG,
    ST_ITEM,
    ST_TOKHI,
    ST_LIT,
    ST_READ,
    ST_COPY
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_chunk;
    logic load_tag;
    logic load_tok_lo;
    logic load_tok_hi;
    logic load_lit;
    logic emit_lit;
    logic issue_read;
    logic emit_copy;
    logic step_flag;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic start;      // current input beat opens a chunk
    logic len_zero;   // its chunk length is zero
    logic flag_bit;   // current flag bit selects a token
    logic last_flag;  // current flag is the eighth of its tag
    logic copy_last;  // one copy byte left
    logic out_last;   // one output byte left in the chunk
    logic slot_free;  // output register can take a beat
  } status_t;

endpackage

// ===== rtl/lz77_window_decompressor.sv =====
// Top level of the lz77 window decompressor (tag byte, 4 KiB ring window).
// Depends on lz77wd_pkg, lz77wd_ctrl and lz77wd_dpath.
//
//   channel   handshake                  payload                 dir
//   comp      comp_valid / comp_ready    comp_beat  (in_beat_t)  in
//   plain     plain_valid / plain_ready  plain_beat (out_beat_t) out
//
// Tag bytes and token low bytes are only taken; a literal is taken, then emitted.
// A token high byte is taken, then each copied byte is read from the window, then emitted.
// Reset leaves the decoder idle; a per-chunk fill count, not a clearing pass,
// decides which window positions read as zero.
// A stalled plain side holds one byte in the output register; comp beats are
// taken until the next byte must be emitted.
`timescale 1ns / 1ps

module lz77_window_decompressor #(
  parameter int unsigned WINDOW_SIZE     = lz77wd_pkg::DEF_WINDOW_SIZE,
  parameter int unsigned MAX_CHUNK_BYTES = lz77wd_pkg::DEF_MAX_CHUNK_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  comp_valid,
  output logic                  comp_ready,
  input  lz77wd_pkg::in_beat_t  comp_beat,
  output logic                  plain_valid,
  input  logic                  plain_ready,
  output lz77wd_pkg::out_beat_t plain_beat
);

  lz77wd_pkg::cmd_t    cmd;
  lz77wd_pkg::status_t sts;

  lz77wd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .valid (comp_valid),
    .ready (comp_ready),
    .sts   (sts),
    .cmd   (cmd)
  );

  lz77wd_dpath #(
    .WINDOW_SIZE     (WINDOW_SIZE),
    .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_beat   (comp_beat),
    .out_valid (plain_valid),
    .out_ready (plain_ready),
    .out_beat  (plain_beat)
  );

endmodule

// ===== rtl/lz77wd_ctrl.sv =====
// Parse and sequencing controller for the lz77 window decompressor.
// Depends on lz77wd_pkg and assert_macros.svh; drives lz77wd_dpath commands.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lz77wd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                ready,
  input  lz77wd_pkg::status_t sts,
  output lz77wd_pkg::cmd_t    cmd
);

  lz77wd_pkg::state_t state;
  lz77wd_pkg::state_t state_next;
  lz77wd_pkg::state_t flag_target;
  logic               take;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lz77wd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Where parsing resumes once the current item is fully emitted
  always_comb begin
    if (sts.out_last) begin
      flag_target = lz77wd_pkg::ST_IDLE;
    end else if (sts.last_flag) begin
      flag_target = lz77wd_pkg::ST_TAG;
    end else begin
      flag_target = lz77wd_pkg::ST_ITEM;
    end
  end

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    ready      = 1'b0;
    take       = valid && !sts.start;
    case (state)
      lz77wd_pkg::ST_IDLE: begin
        ready = 1'b1;
      end
      lz77wd_pkg::ST_TAG: begin
        ready = 1'b1;
        if (take) begin
          cmd.load_tag = 1'b1;
          state_next   = lz77wd_pkg::ST_ITEM;
        end
      end
      lz77wd_pkg::ST_ITEM: begin
        ready = 1'b1;
        if (take && sts.flag_bit) begin
          cmd.load_tok_lo = 1'b1;
          state_next      = lz77wd_pkg::ST_TOKHI;
        end else if (take) begin
          cmd.load_lit = 1'b1;
          state_next   = lz77wd_pkg::ST_LIT;
        end
      end
      lz77wd_pkg::ST_TOKHI: begin
        ready = 1'b1;
        if (take) begin
          cmd.load_tok_hi = 1'b1;
          state_next      = lz77wd_pkg::ST_READ;
        end
      end
      lz77wd_pkg::ST_LIT: begin
        if (sts.slot_free) begin
          cmd.emit_lit  = 1'b1;
          cmd.step_flag = !sts.out_last;
          state_next    = flag_target;
        end
      end
      lz77wd_pkg::ST_READ: begin
        cmd.issue_read = 1'b1;
        state_next     = lz77wd_pkg::ST_COPY;
      end
      lz77wd_pkg::ST_COPY: begin
        if (sts.slot_free) begin
          cmd.emit_copy = 1'b1;
          if (sts.copy_last) begin
            cmd.step_flag = !sts.out_last;
            state_next    = flag_target;
          end else begin
            state_next = lz77wd_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_next = lz77wd_pkg::ST_IDLE;
      end
    endcase

    // A chunk start restarts parsing from any state that takes input
    if (ready && valid && sts.start) begin
      cmd            = '0;
      cmd.load_chunk = 1'b1;
      state_next     = sts.len_zero ? lz77wd_pkg::ST_IDLE : lz77wd_pkg::ST_ITEM;
    end
  end

  // Never emit into a full output register
  `ASSERT_CLK(a_emit_has_slot, clk, rst,
              (cmd.emit_lit || cmd.emit_copy) |-> sts.slot_free)

endmodule

// ===== rtl/lz77wd_dpath.sv =====
// Datapath for the lz77 window decompressor: history window, pointers,
// counters and output register. Depends on lz77wd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lz77wd_dpath #(
  parameter int unsigned WINDOW_SIZE     = lz77wd_pkg::DEF_WINDOW_SIZE,
  parameter int unsigned MAX_CHUNK_BYTES = lz77wd_pkg::DEF_MAX_CHUNK_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lz77wd_pkg::cmd_t      cmd,
  output lz77wd_pkg::status_t   sts,
  input  lz77wd_pkg::in_beat_t  in_beat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lz77wd_pkg::out_beat_t out_beat
);

  localparam int unsigned AW = $clog2(WINDOW_SIZE);
  localparam int unsigned FW = AW + 1;
  localparam int unsigned RW = $clog2(MAX_CHUNK_BYTES + 1);
  localparam int unsigned BW = lz77wd_pkg::BYTE_W;

  logic [BW-1:0] window [WINDOW_SIZE];

  logic [AW-1:0]                     wp;
  logic [AW-1:0]                     rp;
  logic [FW-1:0]                     fill;
  logic [RW-1:0]                     remaining;
  logic [lz77wd_pkg::CNT_W-1:0]      cnt;
  logic [BW-1:0]                     flag_byte;
  logic [lz77wd_pkg::FLAG_IDX_W-1:0] flag_idx;
  logic [BW-1:0]                     tok_lo;
  logic [BW-1:0]                     lit;
  logic [BW-1:0]                     rd_data;
  logic                              rd_hit;

  logic [2*BW-1:0]                   token;
  logic [lz77wd_pkg::CNT_W-1:0]      tok_len;
  logic [RW-1:0]                     len_sat;
  logic                              emit;
  logic [BW-1:0]                     emit_byte;
  logic                              rp_written;

  // Decode the incoming beat
  assign token   = {in_beat.in_byte, tok_lo};
  assign tok_len = lz77wd_pkg::CNT_W'(token[lz77wd_pkg::TOK_LEN_W-1:0])
                 + lz77wd_pkg::CNT_W'(lz77wd_pkg::TOK_LEN_BIAS);
  assign len_sat = (in_beat.chunk_length > lz77wd_pkg::CLEN_W'(MAX_CHUNK_BYTES))
                 ? RW'(MAX_CHUNK_BYTES) : RW'(in_beat.chunk_length);

  // Positions 1..fill were written this chunk; a full window covers all
  assign rp_written = (fill == FW'(WINDOW_SIZE)) ||
                      ((rp != '0) && ({1'b0, rp} <= fill));

  assign emit      = cmd.emit_lit || cmd.emit_copy;
  assign emit_byte = cmd.emit_lit ? lit : (rd_hit ? rd_data : '0);

  // Status back to the controller
  always_comb begin
    sts.start     = in_beat.chunk_start;
    sts.len_zero  = (in_beat.chunk_length == '0);
    sts.flag_bit  = flag_byte[flag_idx];
    sts.last_flag = (flag_idx == '1);
    sts.copy_last = (cnt == lz77wd_pkg::CNT_W'(1));
    sts.out_last  = (remaining == RW'(1));
    sts.slot_free = !out_valid || out_ready;
  end

  // History window: write on every emitted byte, registered read
  always_ff @(posedge clk) begin
    if (emit) begin
      window[wp] <= emit_byte;
    end
    if (cmd.issue_read) begin
      rd_data <= window[rp];
    end
  end

  // Control counters and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= AW'(1);
      fill      <= '0;
      remaining <= '0;
      cnt       <= '0;
      flag_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_chunk) begin
        wp        <= AW'(1);
        fill      <= '0;
        remaining <= len_sat;
        cnt       <= '0;
        flag_idx  <= '0;
      end
      if (cmd.load_tag) begin
        flag_idx <= '0;
      end
      if (cmd.step_flag) begin
        flag_idx <= flag_idx + 1'b1;
      end
      // Clamp the copy length to what the chunk still owes
      if (cmd.load_tok_hi) begin
        cnt <= (remaining < RW'(tok_len)) ? lz77wd_pkg::CNT_W'(remaining) : tok_len;
      end
      if (cmd.emit_copy) begin
        cnt <= cnt - 1'b1;
      end
      if (emit) begin
        wp        <= wp + 1'b1;
        remaining <= remaining - 1'b1;
        if (fill != FW'(WINDOW_SIZE)) begin
          fill <= fill + 1'b1;
        end
      end
      // Output register: load on emit, drop once taken
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_chunk || cmd.load_tag) begin
      flag_byte <= in_beat.in_byte;
    end
    if (cmd.load_tok_lo) begin
      tok_lo <= in_beat.in_byte;
    end
    if (cmd.load_lit) begin
      lit <= in_beat.in_byte;
    end
    if (cmd.load_tok_hi) begin
      rp <= token[lz77wd_pkg::TOK_LEN_W +: AW];
    end else if (cmd.emit_copy) begin
      rp <= rp + 1'b1;
    end
    if (cmd.issue_read) begin
      rd_hit <= rp_written;
    end
    if (emit) begin
      out_beat.out_byte   <= emit_byte;
      out_beat.chunk_last <= (remaining == RW'(1));
    end
  end

  `ASSERT_NEVER(a_fill_bound, clk, rst, fill > FW'(WINDOW_SIZE))
  `ASSERT_CLK(a_copy_within_chunk, clk, rst, RW'(cnt) <= remaining)
  `ASSERT_CLK(a_emit_owed, clk, rst, emit |-> (remaining != '0))
  `ASSERT_CLK(a_wp_tracks_fill, clk, rst,
              (fill < FW'(WINDOW_SIZE)) |-> (wp == fill[AW-1:0] + AW'(1)))

endmodule

// ===== tb/tb_lz77_window_decompressor.sv =====
// Self-checking testbench for lz77_window_decompressor: directed rows, then random chunks.
// Depends on lz77wd_pkg and the RTL; expected plain beats come from typed rows or an in-bench decoder.
`timescale 1ns / 1ps

module tb_lz77_window_decompressor;

  localparam int unsigned WIN     = lz77wd_pkg::DEF_WINDOW_SIZE;
  localparam int unsigned MAX_LEN = lz77wd_pkg::DEF_MAX_CHUNK_BYTES;
  localparam int unsigned IDLE_PCT     = 28;
  localparam int unsigned RANDOM_BEATS = 500;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 40;

  localparam lz77wd_pkg::out_beat_t NB = '{8'h00, 1'b0};  // unused slot
  localparam lz77wd_pkg::out_beat_t Z0 = '{8'h00, 1'b0};  // zero byte, not last
  localparam lz77wd_pkg::out_beat_t ZL = '{8'h00, 1'b1};  // zero byte, last of chunk

  // One directed row; n_typed < 0 leaves the expectation to the decoder
  typedef struct packed {
    lz77wd_pkg::in_beat_t          beat;
    int                            n_typed;
    lz77wd_pkg::out_beat_t [0:2]   outs;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  comp_valid = 1'b0;
  logic                  comp_ready;
  lz77wd_pkg::in_beat_t  comp_beat = '0;
  logic                  plain_valid;
  logic                  plain_ready = 1'b0;
  lz77wd_pkg::out_beat_t plain_beat;

  // Decoder state kept by the bench
  logic [7:0]         win_bytes [WIN];
  logic [WIN-1:0]     win_written;
  logic [11:0]        wr_ptr;
  logic [7:0]         tag_bits;
  logic [2:0]         tag_pos;
  lz77wd_pkg::state_t phase;
  logic [7:0]         tok_lo;
  logic [16:0]        owed;

  lz77wd_pkg::out_beat_t decoded[$];
  lz77wd_pkg::out_beat_t expected_plain[$];

  int  mismatches = 0;
  int  stall_cycles = 0;
  bit  calm = 1'b0;

  dir_row_t dir_rows [20] = '{
    '{'{8'hFF, 1'b0, 17'h00000},  0, '{NB, NB, NB}},                 // byte before any chunk
    '{'{8'hA5, 1'b1, 17'h00000},  0, '{NB, NB, NB}},                 // zero-length chunk
    '{'{8'h00, 1'b0, 17'h1FFFF},  0, '{NB, NB, NB}},                 // idle after it
    '{'{8'h0A, 1'b1, 17'h1FFFF},  0, '{NB, NB, NB}},                 // oversize; tokens on 1, 3
    '{'{8'h00, 1'b0, 17'h00000},  1, '{Z0, NB, NB}},                 // literal zero
    '{'{8'h00, 1'b0, 17'h00000},  0, '{NB, NB, NB}},                 // token low
    '{'{8'hFF, 1'b0, 17'h00000},  2, '{Z0, Z0, NB}},                 // unwritten window read
    '{'{8'hFF, 1'b0, 17'h00000},  1, '{'{8'hFF, 1'b0}, NB, NB}},     // literal all ones
    '{'{8'h5F, 1'b0, 17'h00000},  0, '{NB, NB, NB}},                 // half a token
    '{'{8'h02, 1'b1, 17'd20},     0, '{NB, NB, NB}},                 // restart mid-token
    '{'{8'h41, 1'b0, 17'h00000},  1, '{'{8'h41, 1'b0}, NB, NB}},
    '{'{8'h1F, 1'b0, 17'h00000},  0, '{NB, NB, NB}},
    '{'{8'h00, 1'b0, 17'h00000}, -1, '{NB, NB, NB}},                 // 17-byte overlapping copy
    '{'{8'h42, 1'b0, 17'h00000},  1, '{'{8'h42, 1'b0}, NB, NB}},
    '{'{8'h43, 1'b0, 17'h00000},  1, '{'{8'h43, 1'b1}, NB, NB}},     // last byte of chunk
    '{'{8'hFF, 1'b0, 17'h00000},  0, '{NB, NB, NB}},                 // trailing tag ignored
    '{'{8'h01, 1'b1, 17'd3},      0, '{NB, NB, NB}},                 // token first
    '{'{8'hFF, 1'b0, 17'h00000},  0, '{NB, NB, NB}},
    '{'{8'hFF, 1'b0, 17'h00000},  3, '{Z0, Z0, ZL}},                 // copy cut to length
    '{'{8'h33, 1'b0, 17'h00000},  0, '{NB, NB, NB}}                  // idle after chunk
  };

  lz77_window_decompressor DUT (
    .clk         (clk),
    .rst         (rst),
    .comp_valid  (comp_valid),
    .comp_ready  (comp_ready),
    .comp_beat   (comp_beat),
    .plain_valid (plain_valid),
    .plain_ready (plain_ready),
    .plain_beat  (plain_beat)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Store one output byte in the window and record it
  task automatic put_plain(input logic [7:0] v);
    win_bytes[wr_ptr] = v;
    win_written[wr_ptr] = 1'b1;
    wr_ptr = wr_ptr + 12'd1;
    owed = owed - 17'd1;
    decoded.push_back('{v, owed == 17'd0});
  endtask

  // Advance to the next flag, or go idle once the chunk is complete
  task automatic next_flag();
    if (owed == 17'd0) begin
      phase = lz77wd_pkg::ST_IDLE;
    end else begin
      tag_pos = tag_pos + 3'd1;
      phase = (tag_pos == 3'd0) ? lz77wd_pkg::ST_TAG : lz77wd_pkg::ST_ITEM;
    end
  endtask

  // Decode one compressed beat into the plain bytes it yields
  task automatic decode_beat(input lz77wd_pkg::in_beat_t b);
    logic [15:0] tok;
    logic [11:0] rp;
    int          n;
    if (b.chunk_start) begin
      owed = (b.chunk_length > MAX_LEN) ? 17'(MAX_LEN) : b.chunk_length;
      win_written = '0;
      wr_ptr = 12'd1;
      tag_bits = b.in_byte;
      tag_pos = 3'd0;
      tok_lo = 8'h00;
      phase = (owed == 17'd0) ? lz77wd_pkg::ST_IDLE : lz77wd_pkg::ST_ITEM;
    end else begin
      case (phase)
        lz77wd_pkg::ST_TAG: begin
          tag_bits = b.in_byte;
          tag_pos = 3'd0;
          phase = lz77wd_pkg::ST_ITEM;
        end
        lz77wd_pkg::ST_ITEM: begin
          if (tag_bits[tag_pos]) begin
            tok_lo = b.in_byte;
            phase = lz77wd_pkg::ST_TOKHI;
          end else begin
            put_plain(b.in_byte);
            next_flag();
          end
        end
        lz77wd_pkg::ST_TOKHI: begin
          tok = {b.in_byte, tok_lo};
          rp = tok[15:4];
          n = int'(tok[3:0]) + int'(lz77wd_pkg::TOK_LEN_BIAS);
          if (n > int'(owed)) n = int'(owed);
          for (int i = 0; i < n; i++) begin
            put_plain(win_written[rp] ? win_bytes[rp] : 8'h00);
            rp = rp + 12'd1;
          end
          next_flag();
        end
        default: ;
      endcase
    end
  endtask

  // Drive one beat, hold it until taken, then decode it
  task automatic send_beat(input lz77wd_pkg::in_beat_t b, input bit use_decoder);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      comp_valid <= 1'b0;
      @(negedge clk);
    end
    comp_valid <= 1'b1;
    comp_beat  <= b;
    do @(posedge clk); while (!comp_ready);
    decoded.delete();
    decode_beat(b);
    if (use_decoder) begin
      foreach (decoded[i]) expected_plain.push_back(decoded[i]);
    end
  endtask

  // Stall the plain side at random
  always @(negedge clk) begin
    plain_ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  // Check each plain beat against the oldest expectation
  always @(posedge clk) begin : check_plain
    lz77wd_pkg::out_beat_t want;
    if (!rst && plain_valid && plain_ready) begin
      if (expected_plain.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected plain beat: byte %02h last %0b",
                   plain_beat.out_byte, plain_beat.chunk_last);
      end else begin
        want = expected_plain.pop_front();
        if (plain_beat.out_byte !== want.out_byte ||
            plain_beat.chunk_last !== want.chunk_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("plain beat mismatch: byte exp %02h got %02h, last exp %0b got %0b",
                     want.out_byte, plain_beat.out_byte,
                     want.chunk_last, plain_beat.chunk_last);
        end
      end
    end
  end

  // End the run if no beat moves on either side for too long
  always @(posedge clk) begin
    if (rst || (comp_valid && comp_ready) || (plain_valid && plain_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    lz77wd_pkg::in_beat_t b;
    int                   done_items;
    int                   steps;
    int                   cap;
    int                   r;
    logic [16:0]          len;
    logic [11:0]          tgt;
    logic [7:0]           hi_pending;

    for (int i = 0; i < WIN; i++) win_bytes[i] = 8'h00;
    win_written = '0;
    wr_ptr = 12'd1;
    tag_bits = 8'h00;
    tag_pos = 3'd0;
    phase = lz77wd_pkg::ST_IDLE;
    tok_lo = 8'h00;
    owed = 17'd0;
    hi_pending = 8'h00;
    done_items = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows; typed expectations where they are plain to see
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].beat, dir_rows[i].n_typed < 0);
      for (int j = 0; j < dir_rows[i].n_typed; j++)
        expected_plain.push_back(dir_rows[i].outs[j]);
    end

    // Random chunks: mostly well formed, some cut short or restarted
    while (done_items < RANDOM_BEATS) begin
      calm = (done_items >= 150 && done_items < 250);
      r = $urandom_range(99);
      if (r < 5)       len = 17'd0;
      else if (r < 12) len = 17'($urandom_range(65536, 131071));
      else if (r < 16) len = 17'($urandom_range(81, 65535));
      else             len = 17'($urandom_range(1, 80));
      b.in_byte = 8'($urandom);
      b.chunk_start = 1'b1;
      b.chunk_length = len;
      send_beat(b, 1'b1);
      done_items++;

      steps = 0;
      cap = (len > 17'd200) ? $urandom_range(10, 60) : 1000;
      while (phase != lz77wd_pkg::ST_IDLE && steps < cap && $urandom_range(99) >= 2) begin
        b.chunk_start = 1'b0;
        b.chunk_length = 17'($urandom);
        case (phase)
          lz77wd_pkg::ST_ITEM: begin
            if (tag_bits[tag_pos]) begin
              // aim most tokens at recently written bytes
              if ($urandom_range(99) < 85) begin
                tgt = wr_ptr - 12'($urandom_range(1, 40));
                b.in_byte = {tgt[3:0], 4'($urandom)};
                hi_pending = tgt[11:4];
              end else begin
                b.in_byte = 8'($urandom);
                hi_pending = 8'($urandom);
              end
            end else begin
              b.in_byte = 8'($urandom);
            end
          end
          lz77wd_pkg::ST_TOKHI: b.in_byte = hi_pending;
          default:  b.in_byte = 8'($urandom);
        endcase
        send_beat(b, 1'b1);
        steps++;
        done_items++;
      end

      // feed a few bytes the idle decoder must drop
      if (phase == lz77wd_pkg::ST_IDLE && $urandom_range(99) < 30) begin
        repeat ($urandom_range(1, 3)) begin
          b.in_byte = 8'($urandom);
          b.chunk_start = 1'b0;
          b.chunk_length = 17'($urandom);
          send_beat(b, 1'b1);
        end
      end
    end
    calm = 1'b0;

    @(negedge clk);
    comp_valid <= 1'b0;
    while (expected_plain.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lz77wd_pkg.sv
rtl/lz77wd_ctrl.sv
rtl/lz77wd_dpath.sv
rtl/lz77_window_decompressor.sv
tb/tb_lz77_window_decompressor.sv
